### hdl/hcs_pkg.sv
`timescale 1ns / 1ps
// hcs_pkg: shared types, constants and code tables for the command serializer.
// No dependencies.
package hcs_pkg;

   localparam int TICK_WIDTH = 16;
   localparam int PT_WIDTH   = 16;
   localparam int LIM_WIDTH  = (TICK_WIDTH > PT_WIDTH) ? TICK_WIDTH : PT_WIDTH;
   localparam int FRAME_BITS = 40;
   localparam int BITS_WIDTH = 6;

   localparam logic [TICK_WIDTH-1:0] TICK_MAX     = '1;
   localparam logic [PT_WIDTH-1:0]   PT_RESET     = 16'd35;
   localparam logic [15:0]           FRAME_HEADER = 16'hd5aa;
   localparam logic [7:0]            FRAME_FOOTER = 8'had;
   localparam logic [15:0]           FUNC_OFF     = 16'h0020;
   localparam logic [15:0]           FUNC_BRIGHT  = 16'h00a8;
   localparam logic [15:0]           FUNC_DIM     = 16'h00b8;

   localparam logic [1:0] FN_ON     = 2'd0;
   localparam logic [1:0] FN_OFF    = 2'd1;
   localparam logic [1:0] FN_DIM    = 2'd2;
   localparam logic [1:0] FN_BRIGHT = 2'd3;

   // bit 1 rts, bit 0 dtr
   localparam logic [1:0] LINES_LOW  = 2'b00;
   localparam logic [1:0] LINES_HIGH = 2'b11;
   localparam logic [1:0] LINES_ONE  = 2'b10;
   localparam logic [1:0] LINES_ZERO = 2'b01;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_RESET_LOW = 4'b0010,
      PH_BIT       = 4'b0100,
      PH_HIGH      = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       action;
      logic [3:0] house;
      logic [3:0] unit;
      logic [1:0] func;
   } req_type;

   typedef struct packed {
      logic rts_level;
      logic dtr_level;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } rsp_type;

   function automatic logic [15:0] house_code(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'h6000;
         4'd1:    c = 16'h7000;
         4'd2:    c = 16'h4000;
         4'd3:    c = 16'h5000;
         4'd4:    c = 16'h8000;
         4'd5:    c = 16'h9000;
         4'd6:    c = 16'ha000;
         4'd7:    c = 16'hb000;
         4'd8:    c = 16'he000;
         4'd9:    c = 16'hf000;
         4'd10:   c = 16'hc000;
         4'd11:   c = 16'hd000;
         4'd12:   c = 16'h0000;
         4'd13:   c = 16'h1000;
         4'd14:   c = 16'h2000;
         default: c = 16'h3000;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] unit_code(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'h0010;
         4'd2:    c = 16'h0008;
         4'd3:    c = 16'h0018;
         4'd4:    c = 16'h0040;
         4'd5:    c = 16'h0050;
         4'd6:    c = 16'h0048;
         4'd7:    c = 16'h0058;
         4'd8:    c = 16'h0400;
         4'd9:    c = 16'h0410;
         4'd10:   c = 16'h0408;
         4'd11:   c = 16'h0418;
         4'd12:   c = 16'h0440;
         4'd13:   c = 16'h0450;
         4'd14:   c = 16'h0448;
         default: c = 16'h0458;
      endcase
      return c;
   endfunction

   // zero acts as one; clamp to the counter's range
   function automatic logic [TICK_WIDTH-1:0] tick_limit(input logic [PT_WIDTH-1:0] pt);
      logic [LIM_WIDTH-1:0] lim;
      lim = LIM_WIDTH'(pt);
      if (lim == '0) begin
         lim = LIM_WIDTH'(1);
      end
      if (lim > LIM_WIDTH'(TICK_MAX)) begin
         lim = LIM_WIDTH'(TICK_MAX);
      end
      return lim[TICK_WIDTH-1:0];
   endfunction

endpackage

### hdl/hcs_cmd_enc.sv
`timescale 1ns / 1ps
// hcs_cmd_enc: builds the 16-bit command word from house, unit and function.
// Depends on hcs_pkg.
module hcs_cmd_enc
   import hcs_pkg::*;
(
   input  logic [3:0]  house,
   input  logic [3:0]  unit,
   input  logic [1:0]  func,
   output logic [15:0] cmd
);

   always_comb begin
      unique case (func)
         FN_ON:     cmd = house_code(house) | unit_code(unit);
         FN_OFF:    cmd = house_code(house) | unit_code(unit) | FUNC_OFF;
         FN_DIM:    cmd = house_code(house) | FUNC_DIM;
         FN_BRIGHT: cmd = house_code(house) | FUNC_BRIGHT;
         default:   cmd = house_code(house);
      endcase
   end

endmodule

### hdl/hcs_core.sv
`timescale 1ns / 1ps
// hcs_core: frame state, phase timer and line drive; one item per step.
// Depends on hcs_pkg and hcs_cmd_enc.
module hcs_core
   import hcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_type             req,
   input  logic [PT_WIDTH-1:0] phase_ticks,
   output rsp_type             rsp
);

   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BITS_WIDTH-1:0] bits_ff, bits_in;
   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic                  sending_ff, sending_in;
   logic [1:0]            lines_ff, lines_in;

   logic [15:0]           cmd;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic [TICK_WIDTH-1:0] limit;
   logic                  accepted;
   logic                  done;

   hcs_cmd_enc u_enc (
      .house (req.house),
      .unit  (req.unit),
      .func  (req.func),
      .cmd   (cmd)
   );

   assign limit    = tick_limit(phase_ticks);
   assign tick_inc = tick_ff + 1'b1;

   always_comb begin
      frame_in   = frame_ff;
      bits_in    = bits_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      sending_in = sending_ff;
      lines_in   = lines_ff;
      accepted   = 1'b0;
      done       = 1'b0;
      if (step) begin
         if (req.action) begin
            if (!sending_ff) begin
               frame_in   = {FRAME_HEADER, cmd, FRAME_FOOTER};
               bits_in    = '0;
               phase_in   = PH_RESET_LOW;
               tick_in    = '0;
               sending_in = 1'b1;
               lines_in   = LINES_LOW;
               accepted   = 1'b1;
            end
         end else if (sending_ff) begin
            if (tick_inc < limit) begin
               tick_in = tick_inc;
            end else begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_RESET_LOW: begin
                     phase_in = PH_HIGH;
                     bits_in  = BITS_WIDTH'(FRAME_BITS);
                     lines_in = LINES_HIGH;
                  end
                  PH_BIT: begin
                     phase_in = PH_HIGH;
                     lines_in = LINES_HIGH;
                  end
                  PH_HIGH: begin
                     if (bits_ff != '0) begin
                        lines_in = frame_ff[FRAME_BITS-1] ? LINES_ONE : LINES_ZERO;
                        frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
                        bits_in  = bits_ff - 1'b1;
                        phase_in = PH_BIT;
                     end else begin
                        phase_in   = PH_IDLE;
                        sending_in = 1'b0;
                        lines_in   = LINES_HIGH;
                        done       = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   assign rsp.rts_level  = lines_in[1];
   assign rsp.dtr_level  = lines_in[0];
   assign rsp.busy_res   = sending_in;
   assign rsp.accepted   = accepted;
   assign rsp.frame_done = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         bits_ff    <= '0;
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         sending_ff <= 1'b0;
         lines_ff   <= LINES_HIGH;
      end else begin
         frame_ff   <= frame_in;
         bits_ff    <= bits_in;
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         sending_ff <= sending_in;
         lines_ff   <= lines_in;
      end
   end

   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      sending_ff == (phase_ff != PH_IDLE))
      else $error("busy flag disagrees with phase");

   a_tick_below_limit: assert property (@(posedge clock) disable iff (reset)
      sending_ff && !step |=> tick_ff < limit || !sending_ff || $changed(phase_ticks))
      else $error("tick counter past phase limit");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BITS_WIDTH'(FRAME_BITS))
      else $error("bit count out of range");

   a_bit_lines: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BIT |-> lines_ff[1] != lines_ff[0])
      else $error("bit phase with both lines equal");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> lines_ff == LINES_HIGH)
      else $error("idle with lines not high");

endmodule

### hdl/home_control_command_serializer_top.sv
`timescale 1ns / 1ps
// home_control_command_serializer_top: handshakes, phase register and result register.
// A result is registered and valid the cycle after its item is accepted.
// Throughput: one item per cycle while rsp_ready is high; the result register frees as it is taken.
// Reset (synchronous, active high): idle, lines high, phase_ticks 35, no result.
// Depends on hcs_pkg, hcs_core, hcs_cmd_enc.
module home_control_command_serializer_top
   import hcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PT_WIDTH-1:0] csr_wdata
);

   logic [PT_WIDTH-1:0] phase_ticks_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             core_rsp;
   logic                step;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hcs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (req_data),
      .phase_ticks (phase_ticks_ff),
      .rsp         (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PT_RESET;
      end else if (csr_valid && csr_ready) begin
         phase_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= core_rsp;
      end
   end

   a_acc_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.frame_done))
      else $error("item both accepted and frame done");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> !rsp_ff.busy_res)
      else $error("frame done while still busy");

   a_acc_lines_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.accepted |-> !rsp_ff.rts_level && !rsp_ff.dtr_level
                                          && rsp_ff.busy_res)
      else $error("accepted request without reset-low drive");

endmodule
